// ----- rtl/set_assoc_cache_tag_controller_defines.svh -----
// Assertion macros for the set-associative cache tag controller checker.
// Needs signals clk and rst in the scope where the macros are used.
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_DEFINES_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define SACTC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sactc assertion failed");

// next-cycle implication
`define SACTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sactc assertion failed");

`endif

// ----- rtl/sactc_pkg.sv -----
// Shared constants, set-row and result types for the cache tag controller.
// No dependencies.
`default_nettype none
package sactc_pkg;

  localparam int WAYS   = 8;
  localparam int WAY_W  = 3;
  localparam int SETS   = 64;
  localparam int SET_W  = 6;
  localparam int ADDR_W = 32;
  localparam int TAG_W  = 32;
  localparam int CNT_W  = 4;
  localparam int TREE_W = WAYS - 1;
  localparam int MAX_OB = 16;
  localparam int MAX_IB = 6;

  localparam logic [1:0] POL_RR   = 2'd0;
  localparam logic [1:0] POL_LRU  = 2'd1;
  localparam logic [1:0] POL_PLRU = 2'd2;

  localparam logic [1:0] ST_HIT   = 2'd0;
  localparam logic [1:0] ST_FILL  = 2'd1;
  localparam logic [1:0] ST_CLEAN = 2'd2;
  localparam logic [1:0] ST_DIRTY = 2'd3;

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_OFFSET = 2'd1;
  localparam logic [1:0] REG_INDEX  = 2'd2;

  typedef struct packed {
    logic [WAYS-1:0]             valid;
    logic [WAYS-1:0]             dirty;
    logic [WAYS-1:0][TAG_W-1:0]  tag;
    logic [WAYS-1:0][WAY_W-1:0]  order;
    logic [TREE_W-1:0]           tree;
    logic [WAY_W-1:0]            rr;
    logic [CNT_W-1:0]            count;
  } set_row_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [WAY_W-1:0]  way;
    logic              wb_valid;
    logic [ADDR_W-1:0] wb_addr;
  } result_t;

  function automatic set_row_t reset_row();
    set_row_t r;
    r = '0;
    for (int w = 0; w < WAYS; w++) begin
      r.order[w] = WAY_W'(w);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/sactc_set_mem.sv -----
// Per-set state memory: one row per set, with a registered read.
// Rows never written read as their reset value. Depends on sactc_pkg.
`default_nettype none
module sactc_set_mem (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    rd_en,
  input  wire logic [sactc_pkg::SET_W-1:0] rd_set,
  input  wire logic                    wr_en,
  input  wire logic [sactc_pkg::SET_W-1:0] wr_set,
  input  wire sactc_pkg::set_row_t     wr_row,
  output sactc_pkg::set_row_t          rd_row
);
  import sactc_pkg::*;

  set_row_t        mem [SETS];
  logic [SETS-1:0] row_init;
  set_row_t        rd_q;
  logic            init_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_set] <= wr_row;
    end
    if (rd_en) begin
      rd_q <= mem[rd_set];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_init <= '0;
      init_q   <= 1'b0;
    end else begin
      if (wr_en) begin
        row_init[wr_set] <= 1'b1;
      end
      if (rd_en) begin
        init_q <= row_init[rd_set];
      end
    end
  end

  assign rd_row = init_q ? rd_q : reset_row();

endmodule
`default_nettype wire

// ----- rtl/sactc_lookup.sv -----
// Tag compare, victim choice and policy update for one set row.
// Purely combinational. Depends on sactc_pkg.
`default_nettype none
module sactc_lookup (
  input  wire logic [1:0]                    policy,
  input  wire logic [4:0]                    ob,
  input  wire logic [2:0]                    ib,
  input  wire logic                          kind,
  input  wire logic [sactc_pkg::SET_W-1:0]   set_idx,
  input  wire logic [sactc_pkg::TAG_W-1:0]   tag,
  input  wire sactc_pkg::set_row_t           row,
  output sactc_pkg::result_t                 res,
  output sactc_pkg::set_row_t                row_next
);
  import sactc_pkg::*;

  logic [WAYS-1:0]  match;
  logic             hit;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] vict;
  logic [WAY_W-1:0] way;
  logic [WAY_W:0]   node;
  logic [WAY_W:0]   tnode;
  logic [WAY_W:0]   parent;
  logic [WAY_W-1:0] pos;
  logic             found;
  logic             full;
  logic             is_rr;
  logic [WAY_W-1:0] cand;

  assign is_rr = (policy != POL_LRU) && (policy != POL_PLRU);

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = row.valid[w] && (row.tag[w] == tag);
    end
  end

  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    cand    = '0;
    for (int p = 0; p < WAYS; p++) begin
      cand = (policy == POL_LRU) ? row.order[p] : WAY_W'(p);
      if (!hit && match[cand]) begin
        hit     = 1'b1;
        hit_way = cand;
      end
    end
  end

  always_comb begin
    node = '0;
    case (policy)
      POL_LRU: vict = row.order[WAYS-1];
      POL_PLRU: begin
        for (int l = 0; l < WAY_W; l++) begin
          node = (node << 1) + (WAY_W+1)'(row.tree[node[WAY_W-1:0]]) + 1'b1;
        end
        vict = WAY_W'(node - (WAY_W+1)'(WAYS - 1));
      end
      default: vict = row.rr;
    endcase
  end

  assign way  = hit ? hit_way : vict;
  assign full = row.count >= CNT_W'(WAYS);

  always_comb begin
    row_next     = row;
    res.status   = ST_HIT;
    res.way      = way;
    res.wb_valid = 1'b0;
    res.wb_addr  = '0;
    pos          = WAY_W'(WAYS - 1);
    found        = 1'b0;
    parent       = '0;
    tnode        = '0;
    if (hit) begin
      if (kind) begin
        row_next.dirty[way] = 1'b1;
      end
    end else begin
      res.status = ST_FILL;
      if (row.valid[vict]) begin
        if (row.dirty[vict]) begin
          res.wb_valid = 1'b1;
          res.wb_addr  = ADDR_W'(row.tag[vict] << (6'(ob) + 6'(ib)))
                       | (ADDR_W'(set_idx) << ob);
          if (full) begin
            res.status = ST_DIRTY;
          end
        end else if (full) begin
          res.status = ST_CLEAN;
        end
      end else if (!full) begin
        row_next.count = row.count + 1'b1;
      end
      row_next.tag[vict]   = tag;
      row_next.valid[vict] = 1'b1;
      row_next.dirty[vict] = kind;
      if (is_rr) begin
        row_next.rr = vict + 1'b1;
      end
    end
    if (policy == POL_LRU) begin
      for (int p = 0; p < WAYS; p++) begin
        if (!found && row.order[p] == way) begin
          pos   = WAY_W'(p);
          found = 1'b1;
        end
      end
      for (int i = 1; i < WAYS; i++) begin
        if (WAY_W'(i) <= pos) begin
          row_next.order[i] = row.order[i-1];
        end
      end
      row_next.order[0] = way;
    end else if (policy == POL_PLRU) begin
      tnode = (WAY_W+1)'(way) + (WAY_W+1)'(WAYS - 1);
      for (int l = 0; l < WAY_W; l++) begin
        parent = (tnode - 1'b1) >> 1;
        row_next.tree[parent[WAY_W-1:0]] = tnode[0];
        tnode = parent;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/set_assoc_cache_tag_controller.sv -----
// Top level of the set-associative cache tag and replacement controller.
// Depends on sactc_pkg, sactc_set_mem, sactc_lookup.
//
//  channel | handshake                    | payload
//  in      | in_valid / in_ready          | kind, address
//  out     | out_valid / out_ready        | access_status, way_used, writeback_*
//  cfg     | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// Each transaction runs as a set memory read, then compare and write-back of the
// set row; no new transaction is taken during the compare step.
// Reset clears all valid bits at once through per-set init flags; no sweep.
// A finished result sits in the output register while the next transaction is
// taken; a new one is taken only when that register is free or being drained.
`default_nettype none
module set_assoc_cache_tag_controller (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        kind,
  input  wire logic [31:0] address,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       access_status,
  output logic [2:0]       way_used,
  output logic             writeback_valid,
  output logic [31:0]      writeback_address,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import sactc_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LOOK = 1'b1;

  logic             state;
  logic [1:0]       policy;
  logic [4:0]       offset_bits;
  logic [2:0]       index_bits;
  logic [4:0]       ob;
  logic [2:0]       ib;
  logic             in_acc;
  logic             cfg_wr;
  logic [SET_W-1:0] set_d;
  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;
  logic             kind_q;
  set_row_t         rd_row;
  set_row_t         row_next;
  result_t          res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign ob     = (offset_bits > 5'(MAX_OB)) ? 5'(MAX_OB) : offset_bits;
  assign ib     = (index_bits > 3'(MAX_IB)) ? 3'(MAX_IB) : index_bits;
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign in_acc   = in_valid && in_ready;
  assign set_d    = SET_W'(address >> ob) & SET_W'((7'd1 << ib) - 7'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      policy      <= POL_LRU;
      offset_bits <= 5'd2;
      index_bits  <= 3'd6;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_POLICY: policy      <= pwdata[1:0];
        REG_OFFSET: offset_bits <= pwdata[4:0];
        REG_INDEX:  index_bits  <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_POLICY: prdata = 32'(policy);
      REG_OFFSET: prdata = 32'(offset_bits);
      REG_INDEX:  prdata = 32'(index_bits);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_q <= kind;
      set_q  <= set_d;
      tag_q  <= TAG_W'(address >> (6'(ob) + 6'(ib)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (out_ready) out_valid <= 1'b0;
          if (in_acc) state <= S_LOOK;
        end
        S_LOOK: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LOOK) begin
      access_status     <= res.status;
      way_used          <= res.way;
      writeback_valid   <= res.wb_valid;
      writeback_address <= res.wb_addr;
    end
  end

  sactc_set_mem u_mem (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (in_acc),
    .rd_set (set_d),
    .wr_en  (state == S_LOOK),
    .wr_set (set_q),
    .wr_row (row_next),
    .rd_row (rd_row)
  );

  sactc_lookup u_lookup (
    .policy   (policy),
    .ob       (ob),
    .ib       (ib),
    .kind     (kind_q),
    .set_idx  (set_q),
    .tag      (tag_q),
    .row      (rd_row),
    .res      (res),
    .row_next (row_next)
  );

endmodule
`default_nettype wire

// ----- rtl/sactc_checker.sv -----
// Port-level checker for the cache tag controller, bound to the top level.
// Depends on set_assoc_cache_tag_controller_defines.svh.
`default_nettype none
`include "set_assoc_cache_tag_controller_defines.svh"
module sactc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  access_status,
  input wire logic [2:0]  way_used,
  input wire logic        writeback_valid,
  input wire logic [31:0] writeback_address
);
  import sactc_pkg::*;

  `SACTC_ASSERT_NOW(a_hit_no_wb, out_valid && access_status == ST_HIT, !writeback_valid)
  `SACTC_ASSERT_NOW(a_dirty_wb, out_valid && access_status == ST_DIRTY, writeback_valid)
  `SACTC_ASSERT_NOW(a_clean_no_wb, out_valid && access_status == ST_CLEAN, !writeback_valid)
  `SACTC_ASSERT_NOW(a_wb_addr_zero, out_valid && !writeback_valid, writeback_address == '0)
  `SACTC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(way_used))

endmodule

bind set_assoc_cache_tag_controller sactc_checker u_sactc_checker (.*);
`default_nettype wire

// ----- test/set_assoc_cache_tag_controller_tb.sv -----
// Testbench for the set-associative cache tag controller: drives random and directed
// accesses, predicts hit/miss class, way and write-back per access, and checks results.
// Depends on sactc_pkg and set_assoc_cache_tag_controller.
`timescale 1ns / 1ps
module set_assoc_cache_tag_controller_tb;
  import sactc_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  way;
    logic        wb;
    logic [31:0] wb_addr;
  } access_result_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic        kind = 0;
  logic [31:0] address = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  access_status;
  logic [2:0]  way_used;
  logic        writeback_valid;
  logic [31:0] writeback_address;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [3:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  set_assoc_cache_tag_controller DUT (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // predictor state
  logic [1:0]  policy_q;
  logic [4:0]  offset_q;
  logic [2:0]  index_q;
  logic        valid_m [SETS][WAYS];
  logic        dirty_m [SETS][WAYS];
  logic [31:0] tag_m   [SETS][WAYS];
  int          order_m [SETS][WAYS];
  logic [6:0]  tree_m  [SETS];
  int          rr_m    [SETS];
  int          count_m [SETS];

  access_result_t expected_results[$];
  int  fail_count = 0;
  int  cycle_count = 0;
  int  send_idle = 0;
  int  recv_idle = 0;
  localparam int CYCLE_LIMIT = 400000;

  task automatic touch_way(int s, int w, int pol);
    int pos;
    int node;
    int parent;
    if (pol == POL_LRU) begin
      pos = 0;
      while (pos < WAYS && order_m[s][pos] != w) pos++;
      if (pos >= WAYS) pos = WAYS - 1;
      while (pos > 0) begin
        order_m[s][pos] = order_m[s][pos-1];
        pos--;
      end
      order_m[s][0] = w;
    end else if (pol == POL_PLRU) begin
      node = w + WAYS - 1;
      while (node > 0) begin
        parent = (node - 1) / 2;
        tree_m[s][parent] = node[0];
        node = parent;
      end
    end
  endtask

  task automatic predict_access(logic k, logic [31:0] a);
    access_result_t r;
    int ob, ib, pol, s, w, p, node;
    logic [31:0] tg;
    logic hit;
    ob = offset_q > MAX_OB ? MAX_OB : offset_q;
    ib = index_q > MAX_IB ? MAX_IB : index_q;
    pol = (policy_q == 2'd3) ? POL_RR : policy_q;
    s = (a >> ob) & ((1 << ib) - 1);
    tg = 32'(64'(a) >> (ob + ib));
    r = '0;
    hit = 0;
    w = 0;
    for (p = 0; p < WAYS && !hit; p++) begin
      w = (pol == POL_LRU) ? order_m[s][p] : p;
      if (valid_m[s][w] && tag_m[s][w] == tg) hit = 1;
    end
    if (hit) begin
      if (k) dirty_m[s][w] = 1;
      touch_way(s, w, pol);
      r.status = ST_HIT;
    end else begin
      if (pol == POL_LRU) w = order_m[s][WAYS-1];
      else if (pol == POL_PLRU) begin
        node = 0;
        while (node < WAYS - 1) node = 2 * node + tree_m[s][node] + 1;
        w = node - (WAYS - 1);
      end else begin
        w = rr_m[s];
        rr_m[s] = (w + 1) % WAYS;
      end
      r.status = ST_FILL;
      if (valid_m[s][w]) begin
        if (dirty_m[s][w]) begin
          r.wb = 1;
          r.wb_addr = 32'((64'(tag_m[s][w]) << (ob + ib)) | (64'(s) << ob));
          if (count_m[s] >= WAYS) r.status = ST_DIRTY;
        end else if (count_m[s] >= WAYS) r.status = ST_CLEAN;
      end else if (count_m[s] < WAYS) count_m[s]++;
      tag_m[s][w] = tg;
      valid_m[s][w] = 1;
      dirty_m[s][w] = k;
      touch_way(s, w, pol);
    end
    r.way = w[2:0];
    expected_results.push_back(r);
  endtask

  task automatic send_access(logic k, logic [31:0] a);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    kind <= k;
    address <= a;
    predict_access(k, a);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 0;
    while (expected_results.size() > 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [31:0] value);
    psel <= 1; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
    if (idx == REG_POLICY) policy_q = value[1:0];
    else if (idx == REG_OFFSET) offset_q = value[4:0];
    else if (idx == REG_INDEX) index_q = value[2:0];
  endtask

  task automatic set_layout(logic [1:0] pol, logic [4:0] ob, logic [2:0] ib);
    drain_results();
    write_register(REG_POLICY, 32'(pol));
    write_register(REG_OFFSET, 32'(ob));
    write_register(REG_INDEX, 32'(ib));
  endtask

  // addresses clustered on few tags so sets fill and evict
  function automatic logic [31:0] pick_address();
    logic [31:0] a;
    a = $urandom();
    if ($urandom_range(9) < 8) begin
      a = a & 32'h0000_0FFF;
      a[31:28] = 4'($urandom_range(15));
    end
    return a;
  endfunction

  task automatic test_directed();
    send_access(0, 32'h0000_0000);
    send_access(1, 32'hFFFF_FFFF);
    send_access(0, 32'hFFFF_FFFF);
    send_access(1, 32'h0000_0000);
    for (int i = 0; i < 10; i++) send_access(1, 32'(i) << 8);
    for (int i = 0; i < 10; i++) send_access(0, 32'(i + 10) << 8);
    drain_results();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) drain_results();
      send_access($urandom_range(1), pick_address());
    end
  endtask

  task automatic test_policies();
    set_layout(POL_RR, 0, 0);
    test_random(60);
    set_layout(POL_PLRU, 16, 6);
    test_random(60);
    set_layout(2'd3, 31, 7);
    test_random(50);
    set_layout(POL_LRU, 4, 3);
    test_random(60);
    set_layout(POL_PLRU, 1, 2);
    test_random(60);
    set_layout(POL_RR, 3, 1);
    test_random(60);
  endtask

  always @(posedge clk) begin
    access_result_t e;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("set_assoc_cache_tag_controller_tb: FAIL");
      $finish;
    end
    if (!rst) out_ready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected transaction status=%0d way=%0d", $time,
                 access_status, way_used);
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        if (access_status !== e.status || way_used !== e.way ||
            writeback_valid !== e.wb || writeback_address !== e.wb_addr) begin
          $display("%0t mismatch exp st=%0d way=%0d wb=%0d wa=%h act st=%0d way=%0d wb=%0d wa=%h",
                   $time, e.status, e.way, e.wb, e.wb_addr, access_status, way_used,
                   writeback_valid, writeback_address);
          fail_count++;
        end
      end
    end
  end

  initial begin
    policy_q = POL_LRU;
    offset_q = 2;
    index_q = 6;
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        valid_m[s][w] = 0;
        dirty_m[s][w] = 0;
        tag_m[s][w] = 0;
        order_m[s][w] = w;
      end
      tree_m[s] = 0;
      rr_m[s] = 0;
      count_m[s] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_idle = 17;
    recv_idle = 84;
    test_directed();
    test_policies();
    send_idle = 84;
    recv_idle = 17;
    set_layout(POL_LRU, 2, 6);
    test_random(120);
    send_idle = 0;
    recv_idle = 0;
    set_layout(POL_PLRU, 0, 3);
    test_random(150);
    drain_results();
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("set_assoc_cache_tag_controller_tb: PASS");
    end else begin
      $display("set_assoc_cache_tag_controller_tb: FAIL");
    end
    $finish;
  end
endmodule
